### src/amm_pkg.sv
`default_nettype none
package amm_pkg;

	localparam int MAX_INPUTS     = 16;
	localparam int MAX_OUTPUTS    = 16;
	localparam int SAMPLE_WIDTH   = 24;
	localparam int GAIN_FRAC_BITS = 14;
	localparam int GAIN_BITS      = 18;
	localparam int ACC_BITS       = 46;

	localparam int IN_IDX_W   = 4;
	localparam int OUT_IDX_W  = 4;
	localparam int CMD_W      = 2;
	localparam int PORTS_W    = 5;
	localparam int CNT_W      = $clog2(MAX_OUTPUTS + 1);
	localparam int GAIN_DEPTH = MAX_INPUTS * MAX_OUTPUTS;
	localparam int GAIN_AW    = $clog2(GAIN_DEPTH);
	localparam int OUT_AW     = $clog2(MAX_OUTPUTS);
	localparam int IN_AW      = $clog2(MAX_INPUTS);
	localparam int PROD_W     = SAMPLE_WIDTH + GAIN_BITS;
	localparam int SHIFT_W    = ACC_BITS - GAIN_FRAC_BITS;

	localparam logic [PORTS_W-1:0] PORTS_RESET = PORTS_W'(MAX_OUTPUTS);

	typedef enum logic [CMD_W-1:0] {
		CMD_SET_GAIN = 2'd0,
		CMD_SAMPLE   = 2'd1,
		CMD_CLEAR    = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	typedef struct packed {
		logic                 load;
		logic [OUT_IDX_W-1:0] channel;
		logic                 last;
		logic                 active;
	} out_ctl_t;

endpackage
`default_nettype wire

### src/amm_in_if.sv
`default_nettype none
interface amm_in_if;
	import amm_pkg::*;

	logic                           valid;
	logic                           ready;
	logic [CMD_W-1:0]               cmd;
	logic [IN_IDX_W-1:0]            in_index;
	logic [OUT_IDX_W-1:0]           out_index;
	logic signed [GAIN_BITS-1:0]    gain;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           frame_end;

	modport source (
		output valid, cmd, in_index, out_index, gain, sample, frame_end,
		input  ready
	);

	modport sink (
		input  valid, cmd, in_index, out_index, gain, sample, frame_end,
		output ready
	);

endinterface
`default_nettype wire

### src/amm_out_if.sv
`default_nettype none
interface amm_out_if;
	import amm_pkg::*;

	logic                           valid;
	logic                           ready;
	logic [OUT_IDX_W-1:0]           out_channel;
	logic signed [SAMPLE_WIDTH-1:0] out_sample;
	logic                           saturated;
	logic                           last_of_frame;

	modport source (
		output valid, out_channel, out_sample, saturated, last_of_frame,
		input  ready
	);

	modport sink (
		input  valid, out_channel, out_sample, saturated, last_of_frame,
		output ready
	);

endinterface
`default_nettype wire

### src/amm_ram.sv
`default_nettype none
module amm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### src/amm_out_stage.sv
`default_nettype none
module amm_out_stage (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire amm_pkg::out_ctl_t               ctl,
	input  wire logic signed [amm_pkg::ACC_BITS-1:0] acc,
	output logic                                 out_free,
	amm_out_if.source                            results
);
	import amm_pkg::*;

	logic                           out_v_q;
	logic [OUT_IDX_W-1:0]           channel_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic                           sat_q;
	logic                           last_q;

	logic signed [ACC_BITS-1:0]     shifted;
	logic [SHIFT_W-SAMPLE_WIDTH:0]  top_bits;
	logic                           fits;
	logic signed [SAMPLE_WIDTH-1:0] clipped;
	logic                           clip;

	// An arithmetic shift floors toward minus infinity.
	assign shifted  = acc >>> GAIN_FRAC_BITS;
	assign top_bits = shifted[SHIFT_W-1:SAMPLE_WIDTH-1];
	assign fits     = (&top_bits) | (~|top_bits);

	always_comb begin
		clipped = '0;
		clip    = 1'b0;
		if (ctl.active) begin
			if (fits) begin
				clipped = shifted[SAMPLE_WIDTH-1:0];
			end else begin
				clip    = 1'b1;
				clipped = shifted[SHIFT_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
				                             : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
			end
		end
	end

	assign out_free = !out_v_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (ctl.load) begin
			out_v_q <= 1'b1;
		end else if (results.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			channel_q <= ctl.channel;
			sample_q  <= clipped;
			sat_q     <= clip;
			last_q    <= ctl.last;
		end
	end

	assign results.valid         = out_v_q;
	assign results.out_channel   = channel_q;
	assign results.out_sample    = sample_q;
	assign results.saturated     = sat_q;
	assign results.last_of_frame = last_q;

endmodule
`default_nettype wire

### src/audio_matrix_mixer.sv
`default_nettype none
// Set-gain and clear items are taken in the idle state; a sample item on an active input runs
// through the shared multiply-accumulate over the gain memory for each active output, then drains.
// A frame end then emits the results one at a time through the accumulator memory read port,
// each in a read state and a load state, waiting while the output register is still full.
// Reset clears all gain and accumulator valid bits at once, so both memories read as zero;
// the active counts reset to one and output_ports to 16. No clearing pass is needed.
module audio_matrix_mixer (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [amm_pkg::PORTS_W-1:0]  cfg_wdata,
	amm_in_if.sink                            items,
	amm_out_if.source                         results
);
	import amm_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0]     idx_q, idx_d;
	logic [PORTS_W-1:0]   ports_q;
	logic [CNT_W-1:0]     act_in_q;
	logic [CNT_W-1:0]     act_out_q;
	logic [OUT_IDX_W-1:0] n_m1;

	logic [IN_IDX_W-1:0]            xi_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic                           fend_q;

	logic [GAIN_DEPTH-1:0]  gain_vld_q;
	logic [MAX_OUTPUTS-1:0] acc_vld_q;

	logic accept;
	cmd_t cmd;
	logic in_active;
	logic mac_issue;
	logic emit_rd;
	logic acc_clr;
	logic out_free;
	out_ctl_t out_ctl;

	logic [GAIN_AW-1:0]          gain_waddr;
	logic [GAIN_AW-1:0]          gain_raddr;
	logic                        gain_we;
	logic [GAIN_BITS-1:0]        gain_rdata;
	logic signed [GAIN_BITS-1:0] gain_op;

	logic                       mac_v_s1, mac_v_s2;
	logic [OUT_AW-1:0]          mac_idx_s1, mac_idx_s2;
	logic                       gain_hit_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic                       acc_hit_q;
	logic [OUT_AW-1:0]          acc_raddr;
	logic [ACC_BITS-1:0]        acc_rdata;
	logic signed [ACC_BITS-1:0] acc_old;
	logic signed [ACC_BITS-1:0] acc_sum;
	logic                       acc_we;

	assign items.ready = (state_q == ST_IDLE);
	assign accept      = items.valid && items.ready;
	assign cmd         = cmd_t'(items.cmd);
	assign in_active   = {1'b0, items.in_index} < act_in_q;

	always_comb begin
		if (ports_q == '0) begin
			n_m1 = '0;
		end else if (ports_q > PORTS_W'(MAX_OUTPUTS)) begin
			n_m1 = OUT_IDX_W'(MAX_OUTPUTS - 1);
		end else begin
			n_m1 = OUT_IDX_W'(ports_q - PORTS_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ports_q <= PORTS_RESET;
		end else if (cfg_we) begin
			ports_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		idx_d           = idx_q;
		mac_issue       = 1'b0;
		emit_rd         = 1'b0;
		acc_clr         = 1'b0;
		out_ctl.load    = 1'b0;
		out_ctl.channel = idx_q[OUT_IDX_W-1:0];
		out_ctl.last    = (idx_q[OUT_IDX_W-1:0] == n_m1);
		out_ctl.active  = (idx_q < act_out_q);
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_SAMPLE) begin
					idx_d = '0;
					if (in_active) begin
						state_d = ST_MAC;
					end else if (items.frame_end) begin
						state_d = ST_EMIT_RD;
					end
				end
			end
			ST_MAC: begin
				mac_issue = 1'b1;
				if (idx_q == act_out_q - CNT_W'(1)) begin
					state_d = ST_DRAIN1;
				end else begin
					idx_d = idx_q + CNT_W'(1);
				end
			end
			ST_DRAIN1: begin
				state_d = ST_DRAIN2;
			end
			ST_DRAIN2: begin
				idx_d   = '0;
				state_d = fend_q ? ST_EMIT_RD : ST_IDLE;
			end
			ST_EMIT_RD: begin
				if (out_free) begin
					emit_rd = 1'b1;
					state_d = ST_EMIT_WR;
				end
			end
			ST_EMIT_WR: begin
				out_ctl.load = 1'b1;
				if (out_ctl.last) begin
					acc_clr = 1'b1;
					state_d = ST_IDLE;
				end else begin
					idx_d   = idx_q + CNT_W'(1);
					state_d = ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_in_q   <= CNT_W'(1);
			act_out_q  <= CNT_W'(1);
			gain_vld_q <= '0;
		end else if (accept && cmd == CMD_SET_GAIN) begin
			gain_vld_q[gain_waddr] <= 1'b1;
			if ({1'b0, items.in_index} + CNT_W'(1) > act_in_q) begin
				act_in_q <= {1'b0, items.in_index} + CNT_W'(1);
			end
			if ({1'b0, items.out_index} + CNT_W'(1) > act_out_q) begin
				act_out_q <= {1'b0, items.out_index} + CNT_W'(1);
			end
		end else if (accept && cmd == CMD_CLEAR) begin
			gain_vld_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xi_q     <= items.in_index;
			sample_q <= items.sample;
			fend_q   <= items.frame_end;
		end
	end

	assign gain_we    = accept && cmd == CMD_SET_GAIN;
	assign gain_waddr = {items.in_index[IN_AW-1:0], items.out_index[OUT_AW-1:0]};
	assign gain_raddr = {xi_q[IN_AW-1:0], idx_q[OUT_AW-1:0]};

	amm_ram #(
		.WIDTH (GAIN_BITS),
		.DEPTH (GAIN_DEPTH)
	) u_gain_ram (
		.clk   (clk),
		.we    (gain_we),
		.waddr (gain_waddr),
		.wdata (items.gain),
		.raddr (gain_raddr),
		.rdata (gain_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_v_s1 <= 1'b0;
			mac_v_s2 <= 1'b0;
		end else begin
			mac_v_s1 <= mac_issue;
			mac_v_s2 <= mac_v_s1;
		end
	end

	assign gain_op = gain_hit_s1 ? signed'(gain_rdata) : '0;

	always_ff @(posedge clk) begin
		gain_hit_s1 <= gain_vld_q[gain_raddr];
		mac_idx_s1  <= idx_q[OUT_AW-1:0];
		mac_idx_s2  <= mac_idx_s1;
		prod_s2     <= sample_q * gain_op;
		acc_hit_q   <= acc_vld_q[acc_raddr];
	end

	assign acc_raddr = emit_rd ? idx_q[OUT_AW-1:0] : mac_idx_s1;
	assign acc_old   = acc_hit_q ? signed'(acc_rdata) : '0;
	assign acc_sum   = acc_old + {{(ACC_BITS-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	assign acc_we    = mac_v_s2;

	amm_ram #(
		.WIDTH (ACC_BITS),
		.DEPTH (MAX_OUTPUTS)
	) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (mac_idx_s2),
		.wdata (acc_sum),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
		end else if (acc_clr) begin
			acc_vld_q <= '0;
		end else if (acc_we) begin
			acc_vld_q[mac_idx_s2] <= 1'b1;
		end
	end

	amm_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (out_ctl),
		.acc      (acc_old),
		.out_free (out_free),
		.results  (results)
	);

	a_accept_drained: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !mac_v_s1 && !mac_v_s2)
		else $error("item accepted while accumulations are in flight");

	a_no_write_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		acc_we |-> !emit_rd && !out_ctl.load)
		else $error("accumulator write overlaps frame emission");

	a_clear_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ctl.load && out_ctl.last) |=> acc_vld_q == '0)
		else $error("accumulators not cleared after frame");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_ctl.load |-> $past(out_free))
		else $error("result loaded over a pending transfer");

endmodule
`default_nettype wire

### tb/audio_matrix_mixer_tb.sv
`default_nettype none
module audio_matrix_mixer_tb;
	import amm_pkg::*;

	localparam longint SMP_MAX    = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
	localparam longint SMP_MIN    = -SMP_MAX - 1;
	localparam int     SETTLE     = 48;
	localparam int     CYCLE_CAP  = 1_500_000;
	localparam int     N_PHASES   = 8;
	localparam int     PHASE_SIZE = 52;

	typedef struct packed {
		cmd_t                           cmd;
		logic [IN_IDX_W-1:0]            in_index;
		logic [OUT_IDX_W-1:0]           out_index;
		logic signed [GAIN_BITS-1:0]    gain;
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           frame_end;
	} mix_item_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0]           channel;
		logic signed [SAMPLE_WIDTH-1:0] smp;
		logic                           sat;
		logic                           last;
	} mix_result_t;

	class mix_scoreboard;
		logic signed [GAIN_BITS-1:0] gains [MAX_INPUTS][MAX_OUTPUTS];
		logic signed [ACC_BITS-1:0]  acc [MAX_OUTPUTS];
		int                          act_in;
		int                          act_out;
		logic [PORTS_W-1:0]          ports;
		mix_result_t                 expected_q [$];
		int                          errors;

		function new();
			foreach (gains[i, j]) gains[i][j] = '0;
			foreach (acc[i]) acc[i] = '0;
			act_in  = 1;
			act_out = 1;
			ports   = PORTS_RESET;
			errors  = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string what, longint got, longint want);
			errors++;
			$display("%s mismatch: got %0d, expected %0d", what, got, want);
		endtask

		function void note_item(mix_item_t it);
			longint                     s;
			longint                     p;
			longint                     v;
			logic signed [ACC_BITS-1:0] shifted;
			mix_result_t                r;
			int                         n;
			case (it.cmd)
				CMD_SET_GAIN: begin
					gains[it.in_index][it.out_index] = it.gain;
					if (int'(it.in_index) + 1 > act_in) act_in = int'(it.in_index) + 1;
					if (int'(it.out_index) + 1 > act_out) act_out = int'(it.out_index) + 1;
				end
				CMD_CLEAR: begin
					foreach (gains[i, j]) gains[i][j] = '0;
				end
				CMD_SAMPLE: begin
					if (int'(it.in_index) < act_in) begin
						s = it.sample;
						for (int i = 0; i < act_out; i++) begin
							p = s * longint'(gains[it.in_index][i]);
							acc[i] = acc[i] + p[ACC_BITS-1:0];
						end
					end
					if (it.frame_end) begin
						n = ports;
						if (n < 1) n = 1;
						if (n > MAX_OUTPUTS) n = MAX_OUTPUTS;
						for (int i = 0; i < n; i++) begin
							v = 0;
							r.sat = 1'b0;
							if (i < act_out) begin
								shifted = acc[i] >>> GAIN_FRAC_BITS;
								v = shifted;
								if (v > SMP_MAX) begin
									v = SMP_MAX;
									r.sat = 1'b1;
								end else if (v < SMP_MIN) begin
									v = SMP_MIN;
									r.sat = 1'b1;
								end
							end
							r.channel = i[OUT_IDX_W-1:0];
							r.smp     = v[SAMPLE_WIDTH-1:0];
							r.last    = (i == n - 1);
							expected_q.push_back(r);
						end
						foreach (acc[i]) acc[i] = '0;
					end
				end
				default: ;
			endcase
		endfunction

		task check_result(mix_result_t got);
			mix_result_t want;
			if (expected_q.size() == 0) begin
				report("unexpected result, channel", got.channel, -1);
				return;
			end
			want = expected_q.pop_front();
			if (got.channel !== want.channel) report("out_channel", got.channel, want.channel);
			if (got.smp !== want.smp) report("out_sample", got.smp, want.smp);
			if (got.sat !== want.sat) report("saturated", got.sat, want.sat);
			if (got.last !== want.last) report("last_of_frame", got.last, want.last);
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [PORTS_W-1:0] cfg_wdata;

	amm_in_if  item_ch ();
	amm_out_if result_ch ();

	audio_matrix_mixer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (item_ch),
		.results   (result_ch)
	);

	mix_scoreboard sb = new();
	int            items_sent = 0;
	int            cycles = 0;
	int            rx_stall = 0;
	bit            tx_steady = 1'b0;
	bit            rx_steady = 1'b0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("audio_matrix_mixer test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		mix_result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.channel = result_ch.out_channel;
			got.smp     = result_ch.out_sample;
			got.sat     = result_ch.saturated;
			got.last    = result_ch.last_of_frame;
			sb.check_result(got);
		end
		if (rx_stall > 0) begin
			result_ch.ready <= 1'b0;
			rx_stall--;
		end else if (!rx_steady && $urandom_range(0, 99) < 20) begin
			result_ch.ready <= 1'b0;
			rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	function automatic mix_item_t mk(cmd_t c, int xi, int yi, int g, int s, bit fe);
		mix_item_t it;
		it.cmd       = c;
		it.in_index  = xi[IN_IDX_W-1:0];
		it.out_index = yi[OUT_IDX_W-1:0];
		it.gain      = g[GAIN_BITS-1:0];
		it.sample    = s[SAMPLE_WIDTH-1:0];
		it.frame_end = fe;
		return it;
	endfunction

	function automatic logic signed [GAIN_BITS-1:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return 18'sh1FFFF;
			1: return 18'sh20000;
			2: return 18'sd16384;
			3: return -18'sd16384;
			4: return 18'($urandom_range(0, 64)) - 18'sd32;
			default: return 18'($urandom);
		endcase
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'sh000001;
			3: return 24'shFFFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send(mix_item_t it);
		int gap;
		gap = 0;
		if (!tx_steady) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: gap = 0;
				6, 7, 8: gap = $urandom_range(1, 3);
				default: gap = $urandom_range(5, 30);
			endcase
		end
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.cmd       <= it.cmd;
		item_ch.in_index  <= it.in_index;
		item_ch.out_index <= it.out_index;
		item_ch.gain      <= it.gain;
		item_ch.sample    <= it.sample;
		item_ch.frame_end <= it.frame_end;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		sb.note_item(it);
		if (it.cmd != CMD_NONE) items_sent++;
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_ports(int v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v[PORTS_W-1:0];
		@(posedge clk);
		cfg_we   <= 1'b0;
		sb.ports  = v[PORTS_W-1:0];
	endtask

	task automatic send_frame(int idx_hi);
		int nset;
		int nsamp;
		int xi;
		nset  = $urandom_range(0, 4);
		nsamp = $urandom_range(1, 6);
		for (int k = 0; k < nset; k++)
			send(mk(CMD_SET_GAIN, $urandom_range(0, idx_hi), $urandom_range(0, idx_hi),
				pick_gain(), $urandom, $urandom_range(0, 9) == 0));
		for (int k = 0; k < nsamp; k++) begin
			xi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, idx_hi);
			send(mk(CMD_SAMPLE, xi, $urandom, $urandom, pick_sample(), k == nsamp - 1));
		end
	endtask

	task automatic send_overflow_frame(bit negative);
		send(mk(CMD_SET_GAIN, 0, 0, negative ? -131072 : 131071, 0, 1'b0));
		for (int k = 0; k < 40; k++)
			send(mk(CMD_SAMPLE, 0, 0, 0, 8388607, k == 39));
	endtask

	initial begin
		int port_plan [N_PHASES];
		int idx_hi;
		int r;
		item_ch.valid     <= 1'b0;
		item_ch.cmd       <= CMD_NONE;
		item_ch.in_index  <= '0;
		item_ch.out_index <= '0;
		item_ch.gain      <= '0;
		item_ch.sample    <= '0;
		item_ch.frame_end <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= '0;
		arst_n            <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_ports(16);

		send(mk(CMD_SAMPLE, 0, 0, 0, 8388607, 1'b1));
		send(mk(CMD_SAMPLE, 9, 0, 0, 12345, 1'b1));
		send(mk(CMD_NONE, 15, 15, -1, -1, 1'b1));
		send(mk(CMD_SET_GAIN, 0, 0, 16384, 0, 1'b1));
		send(mk(CMD_SAMPLE, 0, 0, 0, -8388608, 1'b1));
		send(mk(CMD_SET_GAIN, 2, 3, 131071, 0, 1'b0));
		send(mk(CMD_SET_GAIN, 1, 0, -131072, 0, 1'b0));
		send(mk(CMD_SAMPLE, 2, 0, 0, 8388607, 1'b0));
		send(mk(CMD_SAMPLE, 1, 0, 0, 8388607, 1'b0));
		send(mk(CMD_SAMPLE, 0, 0, 0, 1, 1'b1));
		send(mk(CMD_SET_GAIN, 15, 15, 1, 0, 1'b0));
		send(mk(CMD_SAMPLE, 15, 0, 0, -1, 1'b1));
		send(mk(CMD_SAMPLE, 15, 0, 0, 1, 1'b1));
		send(mk(CMD_CLEAR, 0, 0, 0, 0, 1'b1));
		send(mk(CMD_SAMPLE, 2, 0, 0, 8388607, 1'b1));
		send(mk(CMD_SET_GAIN, 4, 4, 16384, 0, 1'b0));
		send(mk(CMD_SAMPLE, 4, 0, 0, 1000, 1'b0));
		send(mk(CMD_CLEAR, 0, 0, 0, 0, 1'b0));
		send(mk(CMD_SAMPLE, 4, 0, 0, 1000, 1'b1));

		port_plan = '{0, 1, 31, 17, 16, 5, $urandom_range(1, 16), $urandom_range(0, 31)};
		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain_results();
			write_ports(port_plan[ph]);
			tx_steady = (ph == 2);
			rx_steady = (ph == 3);
			idx_hi = (ph * 3 + 1 > 15) ? 15 : ph * 3 + 1;
			if (ph == 1) send_overflow_frame(1'b0);
			if (ph == 5) send_overflow_frame(1'b1);
			while (items_sent < 20 + (ph + 1) * PHASE_SIZE) begin
				r = $urandom_range(0, 99);
				if (r < 65)
					send_frame(idx_hi);
				else if (r < 72)
					send(mk(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1)));
				else if (r < 96)
					send(mk(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, pick_gain(),
						pick_sample(), $urandom_range(0, 1)));
				else
					drain_results();
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		drain_results();

		if (sb.errors == 0)
			$display("audio_matrix_mixer test passed");
		else
			$display("audio_matrix_mixer test failed");
		$finish;
	end

endmodule
`default_nettype wire
